@@ hw/rtl/c2h_pkg.sv @@
// c2h_pkg: types, constants and helper functions for the calendar to hex
// epoch file name block. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package c2h_pkg;

    // input word: one calendar reading
    typedef struct packed {
        logic [6:0] year_in_century;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } cal_word_t;

    // output word: one character of the file name
    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
    } chr_word_t;

    // commands to the shared accumulator
    typedef struct packed {
        logic clear;
        logic add;
    } acc_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_SEC,
        ST_SKIP,
        ST_DIGIT,
        ST_SUFFIX
    } state_t;

    localparam int unsigned ACC_W       = 32;
    localparam int unsigned SEC_PER_DAY = 86400;
    localparam int unsigned SEC_PER_HR  = 3600;
    localparam int unsigned SEC_PER_MIN = 60;

    // the year walk starts at 1970, thirty years before the base year
    localparam logic [7:0] YEARS_TO_BASE = 8'd30;
    // 1970 mod 4
    localparam logic [1:0] FIRST_YEAR_MOD = 2'd2;

    localparam logic [ACC_W-1:0] YEAR_SECS      = ACC_W'(365 * SEC_PER_DAY);
    localparam logic [ACC_W-1:0] LEAP_YEAR_SECS = ACC_W'(366 * SEC_PER_DAY);

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_X    = 8'h78;

    localparam logic [1:0] SFX_DOT    = 2'd0;
    localparam logic [1:0] SFX_T_HEAD = 2'd1;
    localparam logic [1:0] SFX_X      = 2'd2;
    localparam logic [1:0] SFX_T_TAIL = 2'd3;

    // seconds in month m; leap selects the 29-day february
    function automatic logic [ACC_W-1:0] month_secs(input logic [3:0] m, input logic leap);
        logic [ACC_W-1:0] secs;
        case (m) inside
            MON_FEB:                          secs = leap ? ACC_W'(29 * SEC_PER_DAY)
                                                          : ACC_W'(28 * SEC_PER_DAY);
            MON_APR, MON_JUN, MON_SEP, MON_NOV: secs = ACC_W'(30 * SEC_PER_DAY);
            default:                          secs = ACC_W'(31 * SEC_PER_DAY);
        endcase
        return secs;
    endfunction

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = CH_ZERO + 8'(nib);
        else
            ch = CH_UP_A + 8'(nib - 4'd10);
        return ch;
    endfunction

    // characters of the ".txt" suffix
    function automatic logic [7:0] suffix_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            SFX_DOT:    ch = CH_DOT;
            SFX_T_HEAD: ch = CH_T;
            SFX_X:      ch = CH_X;
            SFX_T_TAIL: ch = CH_T;
            default:    ch = CH_T;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/c2h_acc.sv @@
// c2h_acc: shared 32-bit accumulator, one wrapping add per cycle.
// Depends on c2h_pkg.
`timescale 1ns / 1ps

module c2h_acc
    import c2h_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  acc_cmd_t         cmd,
    input  logic [ACC_W-1:0] operand,
    output logic [ACC_W-1:0] acc
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    // clear or add modulo 2^32
    always_comb
    begin
        if (cmd.clear)
            acc_next = '0;
        else if (cmd.add)
            acc_next = acc_reg + operand;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/c2h_ctrl.sv @@
// c2h_ctrl: sequencer that feeds the shared accumulator term by term and
// then formats the sum as hex characters plus ".txt". Depends on c2h_pkg.
`timescale 1ns / 1ps

module c2h_ctrl
    import c2h_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cal_valid,
    output logic             cal_ready,
    input  cal_word_t        cal_word,
    output logic             chr_valid,
    input  logic             chr_ready,
    output chr_word_t        chr_word,
    output acc_cmd_t         cmd,
    output logic [ACC_W-1:0] operand,
    input  logic [ACC_W-1:0] acc
);

    state_t     state_reg, state_next;
    cal_word_t  cal_reg, cal_next;
    logic [7:0] year_cnt_reg, year_cnt_next;
    logic [1:0] year_mod_reg, year_mod_next;
    logic [3:0] mon_reg, mon_next;
    logic [2:0] dig_reg, dig_next;
    logic [1:0] sfx_reg, sfx_next;
    logic       out_valid_reg, out_valid_next;
    chr_word_t  out_word_reg, out_word_next;

    logic [3:0] nib;
    logic       can_load;
    logic       leap_in;

    assign nib      = 4'(acc >> {dig_reg, 2'b00});
    assign can_load = !out_valid_reg || chr_ready;
    assign leap_in  = (cal_reg.year_in_century[1:0] == 2'b00);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (cal_valid) state_next = ST_YEAR;
            ST_YEAR:   if (year_cnt_reg == 8'd1) state_next = ST_MONTH;
            ST_MONTH:  if (mon_reg >= cal_reg.month_number) state_next = ST_DAY;
            ST_DAY:    state_next = ST_HOUR;
            ST_HOUR:   state_next = ST_MIN;
            ST_MIN:    state_next = ST_SEC;
            ST_SEC:    state_next = ST_SKIP;
            ST_SKIP:   if (nib != 4'd0 || dig_reg == 3'd0) state_next = ST_DIGIT;
            ST_DIGIT:  if (can_load && dig_reg == 3'd0) state_next = ST_SUFFIX;
            ST_SUFFIX: if (can_load && sfx_reg == SFX_T_TAIL) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath control and output word
    always_comb
    begin
        cal_next      = cal_reg;
        year_cnt_next = year_cnt_reg;
        year_mod_next = year_mod_reg;
        mon_next      = mon_reg;
        dig_next      = dig_reg;
        sfx_next      = sfx_reg;
        out_word_next = out_word_reg;
        out_valid_next = out_valid_reg && !chr_ready;
        cmd           = '0;
        operand       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cal_valid)
                begin
                    cal_next      = cal_word;
                    cmd.clear     = 1'b1;
                    year_cnt_next = YEARS_TO_BASE + 8'(cal_word.year_in_century);
                    year_mod_next = FIRST_YEAR_MOD;
                    mon_next      = 4'd1;
                end
            end
            ST_YEAR:
            begin
                cmd.add       = 1'b1;
                operand       = (year_mod_reg == 2'd0) ? LEAP_YEAR_SECS : YEAR_SECS;
                year_mod_next = year_mod_reg + 2'd1;
                year_cnt_next = year_cnt_reg - 8'd1;
            end
            ST_MONTH:
            begin
                if (mon_reg < cal_reg.month_number)
                begin
                    cmd.add  = 1'b1;
                    operand  = month_secs(mon_reg, leap_in);
                    mon_next = mon_reg + 4'd1;
                end
            end
            ST_DAY:
            begin
                // day zero wraps to minus one day
                cmd.add = 1'b1;
                operand = ACC_W'(ACC_W'(cal_reg.day_of_month) * ACC_W'(SEC_PER_DAY))
                          - ACC_W'(SEC_PER_DAY);
            end
            ST_HOUR:
            begin
                cmd.add = 1'b1;
                operand = ACC_W'(ACC_W'(cal_reg.hour_of_day) * ACC_W'(SEC_PER_HR));
            end
            ST_MIN:
            begin
                cmd.add  = 1'b1;
                operand  = ACC_W'(ACC_W'(cal_reg.minute_of_hour) * ACC_W'(SEC_PER_MIN));
                dig_next = 3'd7;
            end
            ST_SEC:
            begin
                cmd.add = 1'b1;
                operand = ACC_W'(cal_reg.second_of_minute);
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (nib == 4'd0 && dig_reg != 3'd0)
                    dig_next = dig_reg - 3'd1;
            end
            ST_DIGIT:
            begin
                if (can_load)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.name_byte = hex_char(nib);
                    out_word_next.last_byte = 1'b0;
                    if (dig_reg == 3'd0)
                        sfx_next = SFX_DOT;
                    else
                        dig_next = dig_reg - 3'd1;
                end
            end
            ST_SUFFIX:
            begin
                if (can_load)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.name_byte = suffix_char(sfx_reg);
                    out_word_next.last_byte = (sfx_reg == SFX_T_TAIL);
                    sfx_next                = sfx_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            year_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            year_cnt_reg  <= year_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cal_reg      <= cal_next;
        year_mod_reg <= year_mod_next;
        mon_reg      <= mon_next;
        dig_reg      <= dig_next;
        sfx_reg      <= sfx_next;
        out_word_reg <= out_word_next;
    end

    assign cal_ready = (state_reg == ST_IDLE);
    assign chr_valid = out_valid_reg;
    assign chr_word  = out_word_reg;

    // an accepted reading always starts the year walk
    a_accept_to_year: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_valid && cal_ready) |=> (state_reg == ST_YEAR))
        else $error("accepted reading did not start the year walk");

    // the year walk is finished before any month is added
    a_month_after_years: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MONTH) |-> (year_cnt_reg == 8'd0))
        else $error("month phase entered with years left");

    // nothing follows the final character until a new reading is worked
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && chr_ready && out_word_reg.last_byte && state_reg != ST_DIGIT)
        |=> !out_valid_reg)
        else $error("word emitted after the final character");

    // the output register is never overwritten while a word waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !chr_ready && (state_reg == ST_DIGIT || state_reg == ST_SUFFIX))
        |=> $stable(out_word_reg))
        else $error("pending word overwritten");

endmodule

@@ hw/rtl/calendar_to_hex_epoch_filename.sv @@
// Calendar reading to hex epoch file name: one reading in, 5 to 12 words out.
// Sequence: the year walk adds one year of seconds per step from 1970 on the shared
// adder, the month walk adds the months before the given one, then day, hour, minute
// and second are added, leading zero digits are skipped, and each character is loaded
// as the consumer frees the output. Readings go one at a time, accepted only in idle.
// Reset: rst_n asynchronous, active low, returns to idle with no word pending.
`timescale 1ns / 1ps

module calendar_to_hex_epoch_filename
    import c2h_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cal_valid,
    output logic      cal_ready,
    input  cal_word_t cal_word,
    output logic      chr_valid,
    input  logic      chr_ready,
    output chr_word_t chr_word
);

    acc_cmd_t         cmd;
    logic [ACC_W-1:0] operand;
    logic [ACC_W-1:0] acc;

    // sequencer and formatter
    c2h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal_valid (cal_valid),
        .cal_ready (cal_ready),
        .cal_word  (cal_word),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr_word  (chr_word),
        .cmd       (cmd),
        .operand   (operand),
        .acc       (acc)
    );

    // shared seconds accumulator
    c2h_acc u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .operand (operand),
        .acc     (acc)
    );

endmodule

@@ sim/calendar_to_hex_epoch_filename_test.sv @@
// Self-checking testbench for calendar_to_hex_epoch_filename: calendar readings in,
// hex epoch file name characters out, checked against a predictor built in here.
// Depends on c2h_pkg for the word types and on the block's RTL.
`timescale 1ns / 1ps

module calendar_to_hex_epoch_filename_test;
    import c2h_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
    localparam int unsigned SETTLE_CYCLES  = 400;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned HOUR_SECONDS   = 3600;
    localparam int unsigned MINUTE_SECONDS = 60;
    localparam logic [16*8-1:0] HEX_DIGITS  = "0123456789ABCDEF";
    localparam logic [4*8-1:0]  NAME_SUFFIX = ".txt";

    // how willing the name consumer is to take a word
    typedef enum logic [1:0] {
        TAKE_ALL,
        TAKE_MOST,
        TAKE_FEW
    } take_mode_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cal_valid = 1'b0;
    logic      cal_ready;
    cal_word_t cal_word  = '0;
    logic      chr_valid;
    logic      chr_ready = 1'b0;
    chr_word_t chr_word;

    chr_word_t   name_chars_q[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          no_gaps     = 1'b0;
    take_mode_t  take_mode   = TAKE_ALL;
    int unsigned take_run    = 0;

    calendar_to_hex_epoch_filename i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal_valid (cal_valid),
        .cal_ready (cal_ready),
        .cal_word  (cal_word),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr_word  (chr_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, name_chars_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // days in month m; every fourth year has a 29-day february
    function automatic int unsigned month_length(input int unsigned m, input int unsigned yr);
        if (m == 2)
            return (yr % 4 == 0) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // seconds since 1970, wrapping at 32 bits
    function automatic logic [31:0] epoch_seconds(input cal_word_t r);
        logic [31:0] total;
        int unsigned y;
        int unsigned m;
        total = '0;
        for (y = 1970; y < 2000 + int'(r.year_in_century); y++)
            total = total + 32'(((y % 4 == 0) ? 366 : 365) * DAY_SECONDS);
        for (m = 1; m < int'(r.month_number); m++)
            total = total + 32'(month_length(m, r.year_in_century) * DAY_SECONDS);
        total = total + (32'(r.day_of_month) - 32'd1) * 32'(DAY_SECONDS);
        total = total + 32'(r.hour_of_day) * 32'(HOUR_SECONDS);
        total = total + 32'(r.minute_of_hour) * 32'(MINUTE_SECONDS);
        total = total + 32'(r.second_of_minute);
        return total;
    endfunction

    // queue the file name words a reading should produce
    task automatic predict_name(input cal_word_t r);
        logic [31:0] secs;
        logic [3:0]  nib;
        bit          started;
        chr_word_t   w;
        secs    = epoch_seconds(r);
        started = 1'b0;
        for (int d = 7; d >= 0; d--)
        begin
            nib = secs[d*4 +: 4];
            if (nib != 4'd0 || started || d == 0)
            begin
                started     = 1'b1;
                w.name_byte = HEX_DIGITS[(15 - int'(nib))*8 +: 8];
                w.last_byte = 1'b0;
                name_chars_q.push_back(w);
            end
        end
        for (int s = 0; s < 4; s++)
        begin
            w.name_byte = NAME_SUFFIX[(3 - s)*8 +: 8];
            w.last_byte = (s == 3);
            name_chars_q.push_back(w);
        end
    endtask

    function automatic cal_word_t make_reading(input int unsigned yr, input int unsigned mo,
                                               input int unsigned dy, input int unsigned hr,
                                               input int unsigned mi, input int unsigned se);
        cal_word_t r;
        r.year_in_century  = 7'(yr);
        r.month_number     = 4'(mo);
        r.day_of_month     = 5'(dy);
        r.hour_of_day      = 5'(hr);
        r.minute_of_hour   = 6'(mi);
        r.second_of_minute = 6'(se);
        return r;
    endfunction

    // present one reading, wait for it to be taken, then maybe idle a while
    task automatic send_reading(input cal_word_t r);
        int unsigned gap;
        @(negedge clk);
        cal_valid <= 1'b1;
        cal_word  <= r;
        @(posedge clk);
        while (!cal_ready)
            @(posedge clk);
        predict_name(r);
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                cal_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // stop sending until every queued name word has come out
    task automatic wait_for_names();
        @(negedge clk);
        cal_valid <= 1'b0;
        burst_left = 0;
        while (name_chars_q.size() != 0)
            @(posedge clk);
    endtask

    // consumer stalls in runs of differing intensity
    always @(negedge clk)
    begin
        if (take_run == 0)
        begin
            take_mode = take_mode_t'($urandom_range(0, 2));
            take_run  = $urandom_range(20, 200);
        end
        else
            take_run--;
        case (take_mode)
            TAKE_ALL:  chr_ready <= 1'b1;
            TAKE_MOST: chr_ready <= ($urandom_range(0, 3) != 0);
            default:   chr_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // compare each taken word with the oldest expected one
    always @(posedge clk)
    begin
        chr_word_t want;
        if (rst_n && chr_valid && chr_ready)
        begin
            if (name_chars_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected word byte=%h last=%b",
                             $realtime, chr_word.name_byte, chr_word.last_byte);
            end
            else
            begin
                want = name_chars_q.pop_front();
                if (chr_word.name_byte !== want.name_byte
                    || chr_word.last_byte !== want.last_byte)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: word mismatch byte exp=%h got=%h last exp=%b got=%b",
                                 $realtime, want.name_byte, chr_word.name_byte,
                                 want.last_byte, chr_word.last_byte);
                end
            end
        end
    end

    // field extremes, every month class, leap february, day zero
    task automatic test_field_extremes();
        send_reading(make_reading(0, 0, 0, 0, 0, 0));
        send_reading(make_reading(127, 15, 31, 31, 63, 63));
        send_reading(make_reading(0, 1, 1, 0, 0, 0));
        send_reading(make_reading(24, 3, 1, 0, 0, 0));
        send_reading(make_reading(23, 3, 1, 0, 0, 0));
        send_reading(make_reading(20, 3, 0, 12, 0, 0));
        send_reading(make_reading(5, 5, 1, 6, 30, 0));
        send_reading(make_reading(0, 12, 31, 23, 59, 59));
        send_reading(make_reading(99, 12, 31, 23, 59, 59));
        send_reading(make_reading(10, 13, 5, 1, 2, 3));
        send_reading(make_reading(99, 15, 31, 0, 0, 0));
        send_reading(make_reading(50, 6, 15, 31, 63, 63));
    endtask

    // readings that wrap to chosen small values, giving names of one, two and four to seven digits
    task automatic test_name_lengths();
        logic [31:0] wanted [10];
        logic [31:0] base;
        logic [31:0] rest;
        bit          found;
        wanted = '{32'h0, 32'h1, 32'hF, 32'h10, 32'hFF, 32'h1000,
                   32'hFFFFF, 32'h123456, 32'h1234567, 32'hFFFFFFF};
        foreach (wanted[i])
        begin
            found = 1'b0;
            for (int unsigned yr = 0; yr < 128 && !found; yr++)
                for (int unsigned mo = 0; mo < 16 && !found; mo++)
                begin
                    base = epoch_seconds(make_reading(yr, mo, 1, 0, 0, 0));
                    rest = wanted[i] - base;
                    if (rest < 32'(31 * DAY_SECONDS))
                    begin
                        found = 1'b1;
                        send_reading(make_reading(yr, mo, rest / DAY_SECONDS + 1,
                                                  (rest % DAY_SECONDS) / HOUR_SECONDS,
                                                  (rest % HOUR_SECONDS) / MINUTE_SECONDS,
                                                  rest % MINUTE_SECONDS));
                    end
                end
        end
    endtask

    // mostly valid dates, some wrapping years, some raw field values
    task automatic test_random_readings(input int unsigned count);
        int unsigned kind;
        int unsigned yr;
        int unsigned mo;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == count / 3)
                wait_for_names();
            no_gaps = (i >= count / 2 && i < count / 2 + 40);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                yr = $urandom_range(0, 99);
                mo = $urandom_range(1, 12);
                send_reading(make_reading(yr, mo, $urandom_range(1, month_length(mo, yr)),
                                          $urandom_range(0, 23), $urandom_range(0, 59),
                                          $urandom_range(0, 59)));
            end
            else
                send_reading(make_reading((kind == 7) ? $urandom_range(100, 127)
                                                      : $urandom_range(0, 127),
                                          $urandom_range(0, 15), $urandom_range(0, 31),
                                          $urandom_range(0, 31), $urandom_range(0, 63),
                                          $urandom_range(0, 63)));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_name_lengths();
        test_random_readings(450);

        wait_for_names();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (name_chars_q.size() != 0)
        begin
            mismatches++;
            $display("%0d name words never arrived", name_chars_q.size());
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
